// ----- design/nfor_pkg.sv -----
package nfor_pkg;

  localparam int MAX_ANTENNAS    = 4;
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 32;
  localparam int ACNT_W   = 3;
  localparam int POS_W    = (MAX_ANTENNAS > 1) ? $clog2(MAX_ANTENNAS) : 1;
  localparam int CNT_W    = $clog2(MAX_ANTENNAS + 1) + 1;
  localparam int TOP_W    = TABLE_ADDR_BITS + 2;
  localparam int TBL_N    = 1 << TABLE_ADDR_BITS;
  localparam int ROM_AW   = TABLE_ADDR_BITS + 1;
  localparam int TBL_W    = 15;

  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int CFG_AW = 3;

  typedef enum logic [0:0] {
    REG_PHASE_STEP    = 1'b0,
    REG_ANTENNA_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic [TOP_W-1:0]           phase_top;
  } rot_item_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [POS_W-1:0]      pos;
    logic                  last_antenna;
  } front_status_t;

  typedef struct packed {
    logic [OQ_AW:0] oq_count;
    logic [1:0]     inflight;
  } back_status_t;

  typedef logic [TBL_W-1:0] sine_rom_t [0:TBL_N];

  // One Taylor term step: divide by (2i)(2i+1) for i = 1..6.
  function automatic logic [63:0] taylor_div(input logic [63:0] v, input int unsigned i);
    logic [63:0] r;
    case (i)
      1: r = v / 64'd6;
      2: r = v / 64'd20;
      3: r = v / 64'd42;
      4: r = v / 64'd72;
      5: r = v / 64'd110;
      default: r = v / 64'd156;
    endcase
    return r;
  endfunction

  // Quarter-wave sine in unsigned Q0.15, evaluated once at elaboration.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         rom;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       t;
    logic signed [63:0] sum;
    logic [63:0]       v;
    for (int k = 0; k <= TBL_N; k++) begin
      x   = (64'(k) * HALF_PI_Q30) >> TABLE_ADDR_BITS;
      x2  = (x * x) >> 30;
      t   = x;
      sum = signed'(x);
      for (int unsigned i = 1; i <= 6; i++) begin
        t = taylor_div((t * x2) >> 30, i);
        if (i[0]) begin
          sum = sum - signed'(t);
        end else begin
          sum = sum + signed'(t);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      v = (unsigned'(sum) + 64'd16384) >> 15;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[k] = v[TBL_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- design/nfor_front.sv -----
module nfor_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic signed [nfor_pkg::SAMPLE_W-1:0] sample_re,
  input  logic signed [nfor_pkg::SAMPLE_W-1:0] sample_im,
  input  logic                                last_sample,
  input  logic [nfor_pkg::STEP_W-1:0]         phase_step,
  input  logic [nfor_pkg::ACNT_W-1:0]         antenna_count,
  output nfor_pkg::rot_item_t                 item,
  output nfor_pkg::front_status_t             status
);
  import nfor_pkg::*;

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]      cnt_eff;
  logic [CNT_W-1:0]      ac_ext;
  logic                  last_ant;

  assign ac_ext = CNT_W'(antenna_count);

  // Zero counts as one antenna; anything above the maximum is clamped.
  always_comb begin
    if (ac_ext == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (ac_ext > CNT_W'(MAX_ANTENNAS)) begin
      cnt_eff = CNT_W'(MAX_ANTENNAS);
    end else begin
      cnt_eff = ac_ext;
    end
  end

  assign last_ant = (CNT_W'(pos_r) + CNT_W'(1)) >= cnt_eff;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    if (push) begin
      if (last_ant) begin
        pos_nxt   = '0;
        phase_nxt = last_sample ? '0 : phase_r + phase_step[PHASE_BITS-1:0];
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign item.re        = sample_re;
  assign item.im        = sample_im;
  assign item.phase_top = phase_r[PHASE_BITS-1 -: TOP_W];

  assign status.phase        = phase_r;
  assign status.pos          = pos_r;
  assign status.last_antenna = last_ant;

endmodule

// ----- design/nfor_queue.sv -----
module nfor_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  nfor_pkg::rot_item_t wr_item,
  output logic                full,
  input  logic                pop,
  output nfor_pkg::rot_item_t rd_item,
  output logic                empty
);
  import nfor_pkg::*;

  rot_item_t        mem_r [0:Q_DEPTH-1];
  logic [Q_AW-1:0]  wp_r, wp_nxt;
  logic [Q_AW-1:0]  rp_r, rp_nxt;
  logic [Q_AW:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = cnt_r == (Q_AW+1)'(Q_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + Q_AW'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + Q_AW'(1) : rp_r;
    cnt_nxt = cnt_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule

// ----- design/nfor_back.sv -----
module nfor_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  nfor_pkg::rot_item_t                  item,
  input  logic                                 item_valid,
  output logic                                 item_take,
  input  logic                                 pop,
  output logic                                 empty,
  output logic signed [nfor_pkg::SAMPLE_W-1:0] rotated_re,
  output logic signed [nfor_pkg::SAMPLE_W-1:0] rotated_im,
  output logic                                 clipped,
  output nfor_pkg::back_status_t               status
);
  import nfor_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W + 1;
  localparam int SHR_W  = RND_W - 15;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       clip;
  } out_item_t;

  // Stage 1: table reads.
  logic                       v1_r;
  logic signed [SAMPLE_W-1:0] re1_r, im1_r;
  quad_t                      q1_r;
  logic [TBL_W-1:0]           ta_r, tb_r;
  // Stage 2: products.
  logic                       v2_r;
  logic signed [PROD_W-1:0]   p_rc_r, p_is_r, p_rs_r, p_ic_r;
  // Stage 3: sums.
  logic                       v3_r;
  logic signed [SUM_W-1:0]    s_re_r, s_im_r;

  logic [TABLE_ADDR_BITS-1:0] a_idx;
  logic [ROM_AW-1:0]          addr_a, addr_b;
  logic signed [SAMPLE_W-1:0] ta_s, tb_s, sin_v, cos_v;
  logic [1:0]                 inflight;
  logic [OQ_AW:0]             oq_cnt_r, oq_cnt_nxt;
  logic [OQ_AW-1:0]           oq_wp_r, oq_rp_r;
  out_item_t                  oq_r [0:OQ_DEPTH-1];
  out_item_t                  res;
  logic                       clip_re, clip_im;
  logic signed [SAMPLE_W-1:0] sat_re, sat_im;
  logic                       do_pop;

  assign inflight = 2'(v1_r) + 2'(v2_r) + 2'(v3_r);
  // Issue only when every result in flight is sure of a slot in the output queue.
  assign item_take = item_valid &&
                     ((OQ_AW+1)'(oq_cnt_r) + (OQ_AW+1)'(inflight) < (OQ_AW+1)'(OQ_DEPTH));

  assign a_idx  = item.phase_top[TABLE_ADDR_BITS-1:0];
  assign addr_a = ROM_AW'(a_idx);
  assign addr_b = ROM_AW'(TBL_N) - ROM_AW'(a_idx);

  always_ff @(posedge clk) begin
    re1_r <= item.re;
    im1_r <= item.im;
    q1_r  <= quad_t'(item.phase_top[TOP_W-1 -: 2]);
    ta_r  <= SINE_ROM[addr_a];
    tb_r  <= SINE_ROM[addr_b];
  end

  assign ta_s = SAMPLE_W'(ta_r);
  assign tb_s = SAMPLE_W'(tb_r);

  always_comb begin
    case (q1_r)
      QUAD_0: begin
        sin_v = ta_s;
        cos_v = tb_s;
      end
      QUAD_1: begin
        sin_v = tb_s;
        cos_v = -ta_s;
      end
      QUAD_2: begin
        sin_v = -ta_s;
        cos_v = -tb_s;
      end
      QUAD_3: begin
        sin_v = -tb_s;
        cos_v = ta_s;
      end
      default: begin
        sin_v = ta_s;
        cos_v = tb_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p_rc_r <= re1_r * cos_v;
    p_is_r <= im1_r * sin_v;
    p_rs_r <= re1_r * sin_v;
    p_ic_r <= im1_r * cos_v;
    s_re_r <= SUM_W'(p_rc_r) - SUM_W'(p_is_r);
    s_im_r <= SUM_W'(p_rs_r) + SUM_W'(p_ic_r);
  end

  // Round half away from zero: negative sums add one less before the shift.
  function automatic logic signed [SAMPLE_W:0] round_sat(input logic signed [SUM_W-1:0] acc);
    logic signed [RND_W-1:0] t;
    logic signed [SHR_W-1:0] r;
    logic signed [SAMPLE_W:0] o;
    t = RND_W'(acc) + (acc[SUM_W-1] ? RND_W'(16383) : RND_W'(16384));
    r = SHR_W'(t >>> 15);
    if (r > SHR_W'(32767)) begin
      o = {1'b1, 16'sh7FFF};
    end else if (r < -SHR_W'(32768)) begin
      o = {1'b1, 16'sh8000};
    end else begin
      o = {1'b0, r[SAMPLE_W-1:0]};
    end
    return o;
  endfunction

  always_comb begin
    {clip_re, sat_re} = round_sat(s_re_r);
    {clip_im, sat_im} = round_sat(s_im_r);
    res.re   = sat_re;
    res.im   = sat_im;
    res.clip = clip_re || clip_im;
  end

  assign empty  = oq_cnt_r == '0;
  assign do_pop = pop && !empty;
  assign oq_cnt_nxt = oq_cnt_r + (OQ_AW+1)'(v3_r) - (OQ_AW+1)'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      oq_cnt_r <= '0;
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
    end else begin
      v1_r     <= item_take;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      oq_cnt_r <= oq_cnt_nxt;
      if (v3_r) begin
        oq_wp_r <= oq_wp_r + OQ_AW'(1);
      end
      if (do_pop) begin
        oq_rp_r <= oq_rp_r + OQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r) begin
      oq_r[oq_wp_r] <= res;
    end
  end

  assign rotated_re = oq_r[oq_rp_r].re;
  assign rotated_im = oq_r[oq_rp_r].im;
  assign clipped    = oq_r[oq_rp_r].clip;

  assign status.oq_count = oq_cnt_r;
  assign status.inflight = inflight;

endmodule

// ----- design/nco_frequency_offset_rotator_unit.sv -----
// Complex frequency shifter driven by a 32-bit phase accumulator.
// Input channel: samples are offered on in_sample_re/in_sample_im with in_last_sample and
// are taken when in_push is high and in_full is low. All antennas of one time index come
// back to back; the phase advances by phase_step after the last antenna of each index,
// and a request flagged as the final time index clears the phase to zero instead.
// Result channel: the oldest rotated sample sits on out_rotated_re/out_rotated_im/
// out_clipped while out_empty is low and is consumed when out_pop is high.
// Path: a request accepted into the middle queue is registered through the table read,
// product and sum stages, then rounded into the output queue and shown on the result ports.
// Throughput: one request per cycle while the receiver keeps popping. The front end keeps
// the phase and antenna position and classifies each request; a four-entry queue separates
// it from the back end, whose pipeline is limited by one dual-port table read per cycle.
// When the receiver stalls, the back end stops issuing once the eight-entry output queue
// plus the requests in flight would fill it; the middle queue then fills and in_full rises.
// Reset (synchronous, rst_n low) clears the phase, antenna position, queues and pipeline,
// sets phase_step to zero and antenna_count to one. Registers must be written through the
// APB-style port only while the block is idle; the block itself does not enforce this.
module nco_frequency_offset_rotator_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [nfor_pkg::SAMPLE_W-1:0] in_sample_re,
  input  logic signed [nfor_pkg::SAMPLE_W-1:0] in_sample_im,
  input  logic                                 in_last_sample,
  input  logic                                 out_pop,
  output logic                                 out_empty,
  output logic signed [nfor_pkg::SAMPLE_W-1:0] out_rotated_re,
  output logic signed [nfor_pkg::SAMPLE_W-1:0] out_rotated_im,
  output logic                                 out_clipped,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [nfor_pkg::CFG_AW-1:0]          cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);
  import nfor_pkg::*;

  logic [STEP_W-1:0] phase_step_r;
  logic [ACNT_W-1:0] antenna_count_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  rot_item_t     fe_item, be_item;
  front_status_t fe_status;
  back_status_t  be_status;
  logic          q_empty, be_take, in_accept;

  // Register file: index is the word address.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= '0;
      antenna_count_r <= ACNT_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PHASE_STEP:    phase_step_r    <= cfg_pwdata;
        REG_ANTENNA_COUNT: antenna_count_r <= cfg_pwdata[ACNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PHASE_STEP:    cfg_prdata = phase_step_r;
      REG_ANTENNA_COUNT: cfg_prdata = 32'(antenna_count_r);
      default:           cfg_prdata = '0;
    endcase
  end

  assign in_accept = in_push && !in_full;

  nfor_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (in_accept),
    .sample_re     (in_sample_re),
    .sample_im     (in_sample_im),
    .last_sample   (in_last_sample),
    .phase_step    (phase_step_r),
    .antenna_count (antenna_count_r),
    .item          (fe_item),
    .status        (fe_status)
  );

  nfor_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_accept),
    .wr_item (fe_item),
    .full    (in_full),
    .pop     (be_take),
    .rd_item (be_item),
    .empty   (q_empty)
  );

  nfor_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (be_item),
    .item_valid (!q_empty),
    .item_take  (be_take),
    .pop        (out_pop),
    .empty      (out_empty),
    .rotated_re (out_rotated_re),
    .rotated_im (out_rotated_im),
    .clipped    (out_clipped),
    .status     (be_status)
  );

  // A flagged final time index leaves the accumulator at zero.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && fe_status.last_antenna && in_last_sample |=> fe_status.phase == '0)
    else $error("phase not cleared after final time index");

  // The phase only moves on the last antenna of a time index.
  a_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !fe_status.last_antenna |=> $stable(fe_status.phase))
    else $error("phase moved inside a time index");

  // Output queue plus pipeline never exceeds the output queue depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(be_status.oq_count) + 32'(be_status.inflight)) <= OQ_DEPTH)
    else $error("output queue overcommitted");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

// Testbench for the NCO frequency offset rotator.
// Requests go in through a push/full queue port and rotated samples come out through an
// empty/pop queue port. A predictor inside this module keeps its own copy of the phase
// accumulator, the antenna position and both registers. It works out the rotation of
// every accepted request, and the checker compares each popped result against the
// oldest prediction.
module tb;
  import nfor_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 8;     // a little more than the block's pipeline depth
  localparam int STALL_LIMIT   = 4000;  // cycles with no accepted request or result
  localparam int RANDOM_ITEMS  = 1000;
  localparam int RANDOM_PHASES = 8;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       last;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       clipped;
  } rotated_t;

  // One line of the directed table. A row is either a register write or a sample. A sample
  // row may carry its result typed in, which is then used in place of the prediction.
  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [31:0] value;
    sample_t     smp;
    logic        known;
    rotated_t    want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_push = 1'b0;
  logic                       in_full;
  logic signed [SAMPLE_W-1:0] in_sample_re = '0;
  logic signed [SAMPLE_W-1:0] in_sample_im = '0;
  logic                       in_last_sample = 1'b0;
  logic                       out_pop = 1'b0;
  logic                       out_empty;
  logic signed [SAMPLE_W-1:0] out_rotated_re;
  logic signed [SAMPLE_W-1:0] out_rotated_im;
  logic                       out_clipped;
  logic                       cfg_psel = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]          cfg_paddr = '0;
  logic [31:0]                cfg_pwdata = '0;
  logic [31:0]                cfg_prdata;
  logic                       cfg_pready;

  // Predictor state: the registers as written and the block's running phase and position.
  logic [PHASE_BITS-1:0] step_reg = '0;
  logic [ACNT_W-1:0]     count_reg = ACNT_W'(1);
  logic [PHASE_BITS-1:0] phase_acc = '0;
  int                    antenna_pos = 0;
  int                    quarter_sine [0:TBL_N];

  rotated_t pending_rotations [$];
  row_t     directed_rows [$];

  int  mismatches = 0;
  int  requests_sent = 0;
  int  rotations_checked = 0;
  int  register_writes = 0;
  int  stall_cycles = 0;
  int  pop_hold = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_idles = 1'b1;

  nco_frequency_offset_rotator_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_sample_re   (in_sample_re),
    .in_sample_im   (in_sample_im),
    .in_last_sample (in_last_sample),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_rotated_re (out_rotated_re),
    .out_rotated_im (out_rotated_im),
    .out_clipped    (out_clipped),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // The quarter-wave table is built in integer arithmetic: the angle in Q30, a seven-term
  // Taylor series of the sine with every product truncated, then rounding to Q1.15.
  initial begin : sine_setup
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint          series;
    for (int k = 0; k <= TBL_N; k++) begin
      ang    = (64'(k) * HALF_PI_Q30) / TBL_N;
      ang_sq = (ang * ang) >> 30;
      term   = ang;
      series = longint'(ang);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          series = series - longint'(term);
        end else begin
          series = series + longint'(term);
        end
      end
      if (series < 0) begin
        series = 0;
      end
      series = (series + 16384) >>> 15;
      quarter_sine[k] = (series > 32767) ? 32767 : int'(series);
    end
  end

  // Most gaps are absent or short; a few are long enough to back the queues up.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Divide by 2^15, round half away from zero, then saturate to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] round_to_sample(input longint acc,
                                                                 output bit sat);
    longint mag;
    longint r;
    mag = (acc < 0) ? -acc : acc;
    mag = (mag + 16384) >>> 15;
    r   = (acc < 0) ? -mag : mag;
    sat = 1'b0;
    if (r > 32767) begin
      sat = 1'b1;
      r   = 32767;
    end else if (r < -32768) begin
      sat = 1'b1;
      r   = -32768;
    end
    return r[SAMPLE_W-1:0];
  endfunction

  // Rotates one sample by the current phase, then moves the antenna position and the
  // phase on exactly as the block does for an accepted request.
  function automatic rotated_t predict_rotation(sample_t smp);
    logic [TOP_W-1:0] top;
    quad_t            quad;
    int               a;
    longint           sn;
    longint           cs;
    bit               sat_re;
    bit               sat_im;
    int               ants;
    rotated_t         r;
    top  = phase_acc[PHASE_BITS-1 -: TOP_W];
    quad = quad_t'(top[TOP_W-1 -: 2]);
    a    = int'(top[TABLE_ADDR_BITS-1:0]);
    case (quad)
      QUAD_0: begin
        sn = quarter_sine[a];
        cs = quarter_sine[TBL_N - a];
      end
      QUAD_1: begin
        sn = quarter_sine[TBL_N - a];
        cs = -quarter_sine[a];
      end
      QUAD_2: begin
        sn = -quarter_sine[a];
        cs = -quarter_sine[TBL_N - a];
      end
      default: begin
        sn = -quarter_sine[TBL_N - a];
        cs = quarter_sine[a];
      end
    endcase
    r.re = round_to_sample(longint'(smp.re) * cs - longint'(smp.im) * sn, sat_re);
    r.im = round_to_sample(longint'(smp.re) * sn + longint'(smp.im) * cs, sat_im);
    r.clipped = sat_re | sat_im;

    // A count of zero behaves as one antenna and counts above the maximum are clamped.
    ants = int'(count_reg);
    if (ants == 0) ants = 1;
    if (ants > MAX_ANTENNAS) ants = MAX_ANTENNAS;

    // A position left beyond a lowered count is handled as the last antenna. The last
    // mark only counts on the last antenna of a time index, where it clears the phase.
    if (antenna_pos + 1 >= ants) begin
      antenna_pos = 0;
      phase_acc   = smp.last ? '0 : phase_acc + step_reg;
    end else begin
      antenna_pos++;
    end
    return r;
  endfunction

  function automatic row_t write_row(reg_idx_t idx, logic [31:0] value);
    row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.value = value;
    return r;
  endfunction

  function automatic row_t sample_row(int re, int im, bit last);
    row_t r;
    r          = '0;
    r.kind     = ROW_SAMPLE;
    r.smp.re   = SAMPLE_W'(re);
    r.smp.im   = SAMPLE_W'(im);
    r.smp.last = last;
    return r;
  endfunction

  function automatic row_t known_row(int re, int im, bit last, int want_re, int want_im,
                                     bit want_clip);
    row_t r;
    r              = sample_row(re, im, last);
    r.known        = 1'b1;
    r.want.re      = SAMPLE_W'(want_re);
    r.want.im      = SAMPLE_W'(want_im);
    r.want.clipped = want_clip;
    return r;
  endfunction

  // Full-scale values show up often so that rotations saturate now and then.
  function automatic logic signed [SAMPLE_W-1:0] random_part();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0: return -32768;
        1: return -32767;
        2: return -1;
        3: return 0;
        4: return 1;
        default: return 32767;
      endcase
    end
    return SAMPLE_W'($urandom);
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
  endtask

  // Stops feeding and waits until every predicted rotation has been popped, then lets the
  // pipeline settle so that the block is idle before a register changes.
  task automatic wait_drained();
    in_push <= 1'b0;
    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(bit wr, reg_idx_t idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= CFG_AW'(4 * int'(idx));
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes one register once the block is idle, mirrors it into the predictor and reads
  // it back. Only the implemented bits of the antenna count are compared.
  task automatic write_register(reg_idx_t idx, logic [31:0] value);
    logic [31:0] readback;
    bit          bad;
    wait_drained();
    apb_access(1'b1, idx, value, readback);
    if (idx == REG_PHASE_STEP) begin
      step_reg = value;
    end else begin
      count_reg = value[ACNT_W-1:0];
    end
    apb_access(1'b0, idx, '0, readback);
    if (idx == REG_PHASE_STEP) begin
      bad = (readback !== value);
    end else begin
      bad = (readback[ACNT_W-1:0] !== value[ACNT_W-1:0]);
    end
    if (bad) begin
      note_mismatch($sformatf("%s read back 0x%0h, written 0x%0h", idx.name(), readback,
                              value));
    end
    register_writes++;
  endtask

  // Offers one request after an optional gap and holds it until the block takes it. The
  // prediction is made at the edge where the request is accepted.
  task automatic send_request(sample_t smp, bit known, rotated_t want);
    int       gap;
    rotated_t model_out;
    gap = sender_idles ? idle_length() : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_sample_re   <= smp.re;
    in_sample_im   <= smp.im;
    in_last_sample <= smp.last;
    do @(posedge clk); while (in_full);
    model_out = predict_rotation(smp);
    pending_rotations.push_back(known ? want : model_out);
    requests_sent++;
  endtask

  // The receiver pops freely most of the time and stalls for random stretches when its
  // idling is switched on.
  always @(posedge clk) begin
    if (pop_hold > 0) begin
      out_pop  <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      out_pop  <= 1'b1;
      pop_hold <= receiver_idles ? idle_length() : 0;
    end
  end

  // Result checker. Values are sampled as they stood just before the edge. The same block
  // counts cycles in which neither side moved anything, for the watchdog below.
  always @(posedge clk) begin : result_check
    rotated_t want;
    if (rst_n && out_pop && !out_empty) begin
      rotations_checked++;
      if (pending_rotations.size() == 0) begin
        note_mismatch($sformatf("result re=%0d im=%0d clip=%0b arrived with none expected",
                                out_rotated_re, out_rotated_im, out_clipped));
      end else begin
        want = pending_rotations.pop_front();
        if (out_rotated_re !== want.re || out_rotated_im !== want.im ||
            out_clipped !== want.clipped) begin
          note_mismatch($sformatf("expected re=%0d im=%0d clip=%0b, got re=%0d im=%0d clip=%0b",
                                  want.re, want.im, want.clipped,
                                  out_rotated_re, out_rotated_im, out_clipped));
        end
      end
    end
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Watchdog: a run that stops moving for too long is a failure.
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Watchdog expired after %0d idle cycles, %0d rotations still pending",
             stall_cycles, pending_rotations.size());
    $display("FAIL nco_frequency_offset_rotator_unit");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] step_choice;
    logic [31:0] count_choice;
    sample_t     smp;

    // Directed table. While phase and step are zero after reset, the cosine is the top
    // table entry (32767) and the sine is zero, so each part comes out as x*32767/32768
    // rounded. 16384 lands exactly on a half and rounds away from zero.
    directed_rows.push_back(known_row(0, 0, 1'b0, 0, 0, 1'b0));
    directed_rows.push_back(known_row(32767, 32767, 1'b0, 32766, 32766, 1'b0));
    directed_rows.push_back(known_row(-32768, -32768, 1'b0, -32767, -32767, 1'b0));
    directed_rows.push_back(known_row(32767, -32768, 1'b0, 32766, -32767, 1'b0));
    directed_rows.push_back(known_row(16384, -16384, 1'b1, 16384, -16384, 1'b0));
    directed_rows.push_back(known_row(1, -1, 1'b0, 1, -1, 1'b0));
    // An eighth of a turn per sample walks through all four quadrants; the 45 degree
    // point drives full-scale inputs into saturation.
    directed_rows.push_back(write_row(REG_PHASE_STEP, 32'h2000_0000));
    directed_rows.push_back(write_row(REG_ANTENNA_COUNT, 32'd1));
    directed_rows.push_back(sample_row(-32768, -32768, 1'b0));
    directed_rows.push_back(sample_row(-32768, -32768, 1'b0));
    directed_rows.push_back(sample_row(32767, -32768, 1'b0));
    directed_rows.push_back(sample_row(32767, 32767, 1'b0));
    directed_rows.push_back(sample_row(-32768, 32767, 1'b0));
    directed_rows.push_back(sample_row(12345, -23456, 1'b0));
    directed_rows.push_back(sample_row(-32768, -32768, 1'b1));
    directed_rows.push_back(sample_row(32767, 0, 1'b0));
    // Three antennas: a last mark on the first antenna is ignored, one on the third
    // antenna clears the phase.
    directed_rows.push_back(write_row(REG_ANTENNA_COUNT, 32'd3));
    directed_rows.push_back(write_row(REG_PHASE_STEP, 32'h4000_0000));
    directed_rows.push_back(sample_row(1000, 2000, 1'b1));
    directed_rows.push_back(sample_row(-1000, 300, 1'b0));
    directed_rows.push_back(sample_row(30000, -30000, 1'b0));
    directed_rows.push_back(sample_row(-5, 7, 1'b0));
    directed_rows.push_back(sample_row(32767, 32767, 1'b1));
    directed_rows.push_back(sample_row(-32768, 0, 1'b1));
    // Leave the position at the third of four antennas, then lower the count to two so
    // that the next sample sits past the last antenna.
    directed_rows.push_back(write_row(REG_ANTENNA_COUNT, 32'd4));
    directed_rows.push_back(sample_row(111, -222, 1'b0));
    directed_rows.push_back(sample_row(-333, 444, 1'b0));
    directed_rows.push_back(write_row(REG_ANTENNA_COUNT, 32'd2));
    directed_rows.push_back(sample_row(20000, 20000, 1'b0));
    // Out-of-range counts: zero acts as one, seven as the maximum.
    directed_rows.push_back(write_row(REG_ANTENNA_COUNT, 32'd0));
    directed_rows.push_back(sample_row(-20000, 20000, 1'b0));
    directed_rows.push_back(write_row(REG_ANTENNA_COUNT, 32'd7));
    directed_rows.push_back(write_row(REG_PHASE_STEP, 32'hFFFF_FFFF));
    directed_rows.push_back(sample_row(32767, -32768, 1'b0));
    directed_rows.push_back(sample_row(-32768, 32767, 1'b1));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_register(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_request(directed_rows[i].smp, directed_rows[i].known, directed_rows[i].want);
      end
    end

    // Random part in phases. Each phase picks a new step and antenna count, the first ones
    // at the extremes, and switches idling on either side on or off. The per-phase item
    // count is not a multiple of every antenna count, so phases often end mid time index.
    for (int phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
      case (phase_no)
        0: step_choice = 32'hFFFF_FFFF;
        1: step_choice = 32'h0000_0000;
        2: step_choice = 32'h8000_0000;
        3: step_choice = 32'h0000_0001;
        4: step_choice = 32'($urandom_range(1, 65535));
        default: step_choice = $urandom;
      endcase
      case (phase_no)
        0: count_choice = 32'd4;
        1: count_choice = 32'd1;
        2: count_choice = 32'd7;
        3: count_choice = 32'd0;
        default: count_choice = 32'($urandom_range(0, 7));
      endcase
      write_register(REG_PHASE_STEP, step_choice);
      write_register(REG_ANTENNA_COUNT, count_choice);
      sender_idles   = (phase_no % 3 != 0);
      receiver_idles = (phase_no % 4 != 1);
      repeat (RANDOM_ITEMS / RANDOM_PHASES) begin
        smp.re   = random_part();
        smp.im   = random_part();
        smp.last = ($urandom_range(0, 19) == 0);
        send_request(smp, 1'b0, '0);
      end
    end

    wait_drained();

    $display("Run covered %0d requests (%0d directed rows) under %0d register writes.",
             requests_sent, directed_rows.size(), register_writes);
    $display("%0d rotated samples were checked, %0d mismatches found.",
             rotations_checked, mismatches);
    if (mismatches == 0 && pending_rotations.size() == 0) begin
      $display("PASS nco_frequency_offset_rotator_unit");
    end else begin
      $display("FAIL nco_frequency_offset_rotator_unit");
    end
    $finish;
  end

endmodule

// ----- nco_frequency_offset_rotator_unit.f -----
design/nfor_pkg.sv
design/nfor_front.sv
design/nfor_queue.sv
design/nfor_back.sv
design/nco_frequency_offset_rotator_unit.sv
tb/tb.sv
